/* src/asqg_pkg.sv */
// Shared constants, types and helpers for the annulus sector quad generator.
package asqg_pkg;

  localparam int unsigned SegmentsDefault = 100;
  localparam int unsigned AngleW   = 15;
  localparam int unsigned RadiusW  = 12;
  localparam int unsigned ColorW   = 24;
  localparam int unsigned CoordW   = 18;
  localparam int unsigned IndexW   = 7;
  localparam int unsigned TrigW    = 16;
  localparam int unsigned CordicIt = 16;
  localparam int unsigned CordicW  = 34;
  localparam int unsigned ZW       = 20;

  localparam logic signed [AngleW+1:0] PiQ12     = 17'sd12868;
  localparam logic signed [AngleW+1:0] HalfPiQ12 = 17'sd6434;
  localparam logic signed [AngleW+1:0] TwoPiQ12  = 17'sd25736;
  localparam logic signed [CordicW-1:0] CordicK  = 34'sd652032874;
  localparam logic signed [CoordW-1:0] CenterX   = 18'sd15360;
  localparam logic signed [CoordW-1:0] CenterY   = 18'sd8640;
  localparam logic [ColorW-1:0] ColorReset       = 24'hFFFFFF;

  localparam int unsigned AddrW = 5;
  typedef enum logic [AddrW-1:0] {
    RegStart  = 5'd0,
    RegEnd    = 5'd4,
    RegRad0   = 5'd8,
    RegRad1   = 5'd12,
    RegColor  = 5'd16
  } reg_addr_e;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [3:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      4'd0:  v = 20'sd51472;
      4'd1:  v = 20'sd30386;
      4'd2:  v = 20'sd16055;
      4'd3:  v = 20'sd8150;
      4'd4:  v = 20'sd4091;
      4'd5:  v = 20'sd2047;
      4'd6:  v = 20'sd1024;
      4'd7:  v = 20'sd512;
      4'd8:  v = 20'sd256;
      4'd9:  v = 20'sd128;
      4'd10: v = 20'sd64;
      4'd11: v = 20'sd32;
      4'd12: v = 20'sd16;
      4'd13: v = 20'sd8;
      4'd14: v = 20'sd4;
      default: v = 20'sd2;
    endcase
    return v;
  endfunction

  // folded angle request handed from front to back
  typedef struct packed {
    logic signed [ZW-1:0] z0;
    logic                 neg0;
    logic signed [ZW-1:0] z1;
    logic                 neg1;
    logic [RadiusW-1:0]   rad0;
    logic [RadiusW-1:0]   rad1;
    logic [ColorW-1:0]    color;
  } front_req_t;

endpackage

/* src/annulus_sector_quad_generator.sv */
// Top level: APB registers, front end, request queue and CORDIC back end.
// One segment request is taken per cycle unless the input is stalled; a request
// passes through 3 front stages, one queue stage, a back-end input stage, 16
// pipelined CORDIC stages for both edge angles and one scaling stage before its
// result is presented. A full queue stalls the input.
module annulus_sector_quad_generator #(
  parameter int unsigned Segments = asqg_pkg::SegmentsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [asqg_pkg::AddrW-1:0]           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 valid_i,
  output logic                                 stall_o,
  input  logic [asqg_pkg::IndexW-1:0]          segment_index_i,
  output logic                                 valid_o,
  input  logic                                 stall_i,
  output logic signed [asqg_pkg::CoordW-1:0]   corner0_x_o,
  output logic signed [asqg_pkg::CoordW-1:0]   corner0_y_o,
  output logic signed [asqg_pkg::CoordW-1:0]   corner1_x_o,
  output logic signed [asqg_pkg::CoordW-1:0]   corner1_y_o,
  output logic signed [asqg_pkg::CoordW-1:0]   corner2_x_o,
  output logic signed [asqg_pkg::CoordW-1:0]   corner2_y_o,
  output logic signed [asqg_pkg::CoordW-1:0]   corner3_x_o,
  output logic signed [asqg_pkg::CoordW-1:0]   corner3_y_o,
  output logic [asqg_pkg::ColorW-1:0]          vertex_color_o
);
  import asqg_pkg::*;

  logic signed [AngleW-1:0] start_q, end_q;
  logic [RadiusW-1:0]       rad0_q, rad1_q;
  logic [ColorW-1:0]        color_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= '0;
      rad0_q  <= '0;
      rad1_q  <= '0;
      color_q <= ColorReset;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        RegStart: start_q <= pwdata[AngleW-1:0];
        RegEnd:   end_q   <= pwdata[AngleW-1:0];
        RegRad0:  rad0_q  <= pwdata[RadiusW-1:0];
        RegRad1:  rad1_q  <= pwdata[RadiusW-1:0];
        RegColor: color_q <= pwdata[ColorW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      RegStart: prdata = 32'(start_q);
      RegEnd:   prdata = 32'(end_q);
      RegRad0:  prdata = 32'(rad0_q);
      RegRad1:  prdata = 32'(rad1_q);
      RegColor: prdata = 32'(color_q);
      default:  prdata = '0;
    endcase
  end

  logic       f_valid, f_stall, q_valid, q_stall;
  front_req_t f_req, q_req;

  asqg_front #(.Segments(Segments)) u_front (
    .clk_i, .rst_ni,
    .valid_i, .stall_o,
    .index_i (segment_index_i),
    .start_i (start_q), .end_i (end_q),
    .rad0_i (rad0_q), .rad1_i (rad1_q), .color_i (color_q),
    .valid_o (f_valid), .stall_i (f_stall), .req_o (f_req)
  );

  asqg_fifo #(.Depth(4)) u_fifo (
    .clk_i, .rst_ni,
    .valid_i (f_valid), .stall_o (f_stall), .req_i (f_req),
    .valid_o (q_valid), .stall_i (q_stall), .req_o (q_req)
  );

  asqg_back u_back (
    .clk_i, .rst_ni,
    .valid_i (q_valid), .stall_o (q_stall), .req_i (q_req),
    .valid_o, .stall_i,
    .c0x_o (corner0_x_o), .c0y_o (corner0_y_o),
    .c1x_o (corner1_x_o), .c1y_o (corner1_y_o),
    .c2x_o (corner2_x_o), .c2y_o (corner2_y_o),
    .c3x_o (corner3_x_o), .c3y_o (corner3_y_o),
    .color_o (vertex_color_o)
  );

endmodule

/* src/asqg_front.sv */
// Front end: clamps index, computes edge angles, wraps and folds them.
module asqg_front #(
  parameter int unsigned Segments = asqg_pkg::SegmentsDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  stall_o,
  input  logic [asqg_pkg::IndexW-1:0]           index_i,
  input  logic signed [asqg_pkg::AngleW-1:0]    start_i,
  input  logic signed [asqg_pkg::AngleW-1:0]    end_i,
  input  logic [asqg_pkg::RadiusW-1:0]          rad0_i,
  input  logic [asqg_pkg::RadiusW-1:0]          rad1_i,
  input  logic [asqg_pkg::ColorW-1:0]           color_i,
  output logic                                  valid_o,
  input  logic                                  stall_i,
  output asqg_pkg::front_req_t                  req_o
);
  import asqg_pkg::*;

  localparam int unsigned KW   = $clog2(Segments + 1) + 1;
  localparam int unsigned ProdW = AngleW + 1 + KW;
  localparam int unsigned RecS  = ProdW + 8;
  // reciprocal for exact division of |d*k| < 2^(ProdW-1) by Segments
  localparam longint unsigned RecM = ((64'd1 << RecS) + Segments - 1) / Segments;
  localparam int unsigned RecW  = RecS + 2 - $clog2(Segments + 1) + 1;

  // stage 0: register clamped k and difference
  logic               v0_q, v1_q;
  logic [KW-1:0]      k_q;
  logic signed [AngleW:0] diff_q;
  logic signed [AngleW-1:0] st0_q, st1_q;
  logic [RadiusW-1:0] r0a_q, r1a_q, r0b_q, r1b_q;
  logic [ColorW-1:0]  ca_q, cb_q;
  logic [ProdW-1:0]   p0_q, p1_q;
  logic               s0_q, s1_q;

  logic adv;
  assign adv = !(valid_o && stall_i);
  assign stall_o = !adv;

  logic [KW-1:0] k_d;
  always_comb begin
    if ({1'b0, index_i} > (IndexW + 1)'(Segments - 1)) k_d = KW'(Segments - 1);
    else k_d = KW'(index_i);
  end

  // products d*k and d*(k+1), magnitudes
  logic signed [ProdW-1:0] pa, pb;
  assign pa = ProdW'(diff_q) * $signed({1'b0, k_q});
  assign pb = ProdW'(diff_q) * $signed({1'b0, k_q + KW'(1)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (adv) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      k_q    <= k_d;
      diff_q <= (AngleW + 1)'(end_i) - (AngleW + 1)'(start_i);
      st0_q  <= start_i;
      r0a_q  <= rad0_i;
      r1a_q  <= rad1_i;
      ca_q   <= color_i;
      st1_q  <= st0_q;
      r0b_q  <= r0a_q;
      r1b_q  <= r1a_q;
      cb_q   <= ca_q;
      s0_q   <= pa[ProdW-1];
      s1_q   <= pb[ProdW-1];
      p0_q   <= pa[ProdW-1] ? ProdW'(-pa) : ProdW'(pa);
      p1_q   <= pb[ProdW-1] ? ProdW'(-pb) : ProdW'(pb);
    end
  end

  function automatic logic signed [AngleW+2:0] quot(input logic [ProdW-1:0] m,
                                                    input logic s);
    logic [ProdW+RecW-1:0] prod;
    logic [AngleW+1:0]     q;
    prod = (ProdW + RecW)'(m) * (ProdW + RecW)'(RecM);
    q = (AngleW + 2)'(prod >> RecS);
    return s ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  function automatic void fold(input logic signed [AngleW+2:0] a_in,
                               output logic signed [ZW-1:0] z,
                               output logic n);
    logic signed [AngleW+2:0] a;
    a = a_in;
    n = 1'b0;
    if (a > (AngleW + 3)'(PiQ12)) a = a - (AngleW + 3)'(TwoPiQ12);
    if (a < -(AngleW + 3)'(PiQ12)) a = a + (AngleW + 3)'(TwoPiQ12);
    if (a > (AngleW + 3)'(HalfPiQ12)) begin
      a = a - (AngleW + 3)'(PiQ12);
      n = 1'b1;
    end else if (a < -(AngleW + 3)'(HalfPiQ12)) begin
      a = a + (AngleW + 3)'(PiQ12);
      n = 1'b1;
    end
    z = ZW'(a) <<< 4;
  endfunction

  front_req_t req_d;
  logic signed [AngleW+2:0] a0, a1;
  always_comb begin
    a0 = (AngleW + 3)'(st1_q) + quot(p0_q, s0_q);
    a1 = (AngleW + 3)'(st1_q) + quot(p1_q, s1_q);
    fold(a0, req_d.z0, req_d.neg0);
    fold(a1, req_d.z1, req_d.neg1);
    req_d.rad0  = r0b_q;
    req_d.rad1  = r1b_q;
    req_d.color = cb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else if (adv) valid_o <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) req_o <= req_d;
  end

endmodule

/* src/asqg_fifo.sv */
// Short request queue between front and back ends.
module asqg_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  asqg_pkg::front_req_t req_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output asqg_pkg::front_req_t req_o
);
  import asqg_pkg::*;

  localparam int unsigned PW = $clog2(Depth);

  front_req_t      mem_q [Depth];
  logic [PW-1:0]   wp_q, rp_q;
  logic [PW:0]     cnt_q;
  logic            push, pop;

  assign stall_o = cnt_q == (PW + 1)'(Depth);
  assign valid_o = cnt_q != '0;
  assign push    = valid_i && !stall_o;
  assign pop     = valid_o && !stall_i;
  assign req_o   = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == PW'(Depth - 1)) ? '0 : wp_q + PW'(1);
      if (pop)  rp_q <= (rp_q == PW'(Depth - 1)) ? '0 : rp_q + PW'(1);
      cnt_q <= cnt_q + (PW + 1)'(push) - (PW + 1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= req_i;
  end

`ifndef ASSERT_OFF
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW + 1)'(Depth)) else $error("queue count overflow");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + (PW + 1)'(1))
    else $error("queue count missed push");
  a_ptr_eq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wp_q == rp_q)) else $error("empty queue pointers differ");
`endif

endmodule

/* src/asqg_back.sv */
// Back end: pipelined CORDIC for both angles, then radius scaling.
module asqg_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  asqg_pkg::front_req_t                req_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output logic signed [asqg_pkg::CoordW-1:0]  c0x_o,
  output logic signed [asqg_pkg::CoordW-1:0]  c0y_o,
  output logic signed [asqg_pkg::CoordW-1:0]  c1x_o,
  output logic signed [asqg_pkg::CoordW-1:0]  c1y_o,
  output logic signed [asqg_pkg::CoordW-1:0]  c2x_o,
  output logic signed [asqg_pkg::CoordW-1:0]  c2y_o,
  output logic signed [asqg_pkg::CoordW-1:0]  c3x_o,
  output logic signed [asqg_pkg::CoordW-1:0]  c3y_o,
  output logic [asqg_pkg::ColorW-1:0]         color_o
);
  import asqg_pkg::*;

  localparam int unsigned NS = CordicIt + 2;
  localparam int unsigned PrW = TrigW + RadiusW + 1;

  logic adv;
  assign adv = !(valid_o && stall_i);
  assign stall_o = !adv;

  logic signed [CordicW-1:0] x0_q [CordicIt+1], y0_q [CordicIt+1];
  logic signed [CordicW-1:0] x1_q [CordicIt+1], y1_q [CordicIt+1];
  logic signed [ZW-1:0]      z0_q [CordicIt+1], z1_q [CordicIt+1];
  logic                      n0_q [CordicIt+1], n1_q [CordicIt+1];
  logic [RadiusW-1:0]        ra_q [CordicIt+1], rb_q [CordicIt+1];
  logic [ColorW-1:0]         col_q [CordicIt+1];
  logic                      v_q [NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NS; s++) v_q[s] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= valid_i;
      for (int s = 1; s < NS; s++) v_q[s] <= v_q[s-1];
    end
  end
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x0_q[0] <= CordicK;  y0_q[0] <= '0;  z0_q[0] <= req_i.z0; n0_q[0] <= req_i.neg0;
      x1_q[0] <= CordicK;  y1_q[0] <= '0;  z1_q[0] <= req_i.z1; n1_q[0] <= req_i.neg1;
      ra_q[0] <= req_i.rad0;
      rb_q[0] <= req_i.rad1;
      col_q[0] <= req_i.color;
    end
  end

  for (genvar i = 0; i < CordicIt; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (!z0_q[i][ZW-1]) begin
          x0_q[i+1] <= x0_q[i] - (y0_q[i] >>> i);
          y0_q[i+1] <= y0_q[i] + (x0_q[i] >>> i);
          z0_q[i+1] <= z0_q[i] - atan_lut(4'(i));
        end else begin
          x0_q[i+1] <= x0_q[i] + (y0_q[i] >>> i);
          y0_q[i+1] <= y0_q[i] - (x0_q[i] >>> i);
          z0_q[i+1] <= z0_q[i] + atan_lut(4'(i));
        end
        if (!z1_q[i][ZW-1]) begin
          x1_q[i+1] <= x1_q[i] - (y1_q[i] >>> i);
          y1_q[i+1] <= y1_q[i] + (x1_q[i] >>> i);
          z1_q[i+1] <= z1_q[i] - atan_lut(4'(i));
        end else begin
          x1_q[i+1] <= x1_q[i] + (y1_q[i] >>> i);
          y1_q[i+1] <= y1_q[i] - (x1_q[i] >>> i);
          z1_q[i+1] <= z1_q[i] + atan_lut(4'(i));
        end
        n0_q[i+1]  <= n0_q[i];
        n1_q[i+1]  <= n1_q[i];
        ra_q[i+1]  <= ra_q[i];
        rb_q[i+1]  <= rb_q[i];
        col_q[i+1] <= col_q[i];
      end
    end
  end

  function automatic logic signed [TrigW-1:0] rnd(input logic signed [CordicW-1:0] v,
                                                  input logic n);
    logic signed [CordicW-1:0] r;
    r = (v + CordicW'(32768)) >>> 16;
    return n ? -TrigW'(r) : TrigW'(r);
  endfunction

  function automatic logic signed [CoordW-1:0] crd(input logic signed [CoordW-1:0] c,
                                                   input logic signed [TrigW-1:0] t,
                                                   input logic [RadiusW-1:0] r);
    logic signed [PrW-1:0] p;
    p = PrW'(t) * $signed({1'b0, r});
    p = (p + PrW'(512)) >>> 10;
    return c + CoordW'(p);
  endfunction

  logic signed [TrigW-1:0] c0, s0, c1, s1;
  assign c0 = rnd(x0_q[CordicIt], n0_q[CordicIt]);
  assign s0 = rnd(y0_q[CordicIt], n0_q[CordicIt]);
  assign c1 = rnd(x1_q[CordicIt], n1_q[CordicIt]);
  assign s1 = rnd(y1_q[CordicIt], n1_q[CordicIt]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c0x_o   <= crd(CenterX, c0, ra_q[CordicIt]);
      c0y_o   <= crd(CenterY, s0, ra_q[CordicIt]);
      c1x_o   <= crd(CenterX, c0, rb_q[CordicIt]);
      c1y_o   <= crd(CenterY, s0, rb_q[CordicIt]);
      c2x_o   <= crd(CenterX, c1, rb_q[CordicIt]);
      c2y_o   <= crd(CenterY, s1, rb_q[CordicIt]);
      c3x_o   <= crd(CenterX, c1, ra_q[CordicIt]);
      c3y_o   <= crd(CenterY, s1, ra_q[CordicIt]);
      color_o <= col_q[CordicIt];
    end
  end

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> valid_o && $stable(c0x_o) && $stable(color_o))
    else $error("result changed under stall");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!stall_o && v_q[NS-2]) |=> valid_o) else $error("result lost");
  a_stallsrc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i)) else $error("spurious stall");
`endif

endmodule
